FILE: rtl/ktk_pkg.sv
// Package for the keyed top-k score table.
// Transaction structs, cell control structs, status codes and fixed sizes.
// No dependencies.
`default_nettype none

package ktk_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_W      = 4;     // bits of a table position
    localparam int CNT_W      = 5;     // bits of an entry count, 0..ENTRIES
    localparam int KEY_BITS   = 64;
    localparam int SCORE_BITS = 32;

    localparam logic       OP_SUBMIT = 1'b0;
    localparam logic       OP_READ   = 1'b1;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_IMPROVED = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    typedef struct packed {
        logic                  opcode;
        logic [KEY_BITS-1:0]   name_key;
        logic [SCORE_BITS-1:0] new_score;
        logic [IDX_W-1:0]      read_index;
    } item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [CNT_W-1:0]      rank;
        logic [CNT_W-1:0]      entry_count;
        logic                  entry_valid;
        logic [KEY_BITS-1:0]   entry_key;
        logic [SCORE_BITS-1:0] entry_score;
    } result_t;

    // per-cell update command
    typedef struct packed {
        logic load;     // take the probe key and score
        logic shift;    // take the left neighbour's entry
    } cell_ctl_t;

    // per-cell compare flags
    typedef struct packed {
        logic match;    // stored key equals the probe key
        logic gt;       // probe score strictly above the stored score
    } cell_flags_t;

endpackage

`default_nettype wire

FILE: rtl/keyed_top_k_score_table.sv
// Keyed top-k score table. Each transaction runs a compare phase across all cells, then
// an update phase in which the cells load or shift. A new transaction is taken during
// the update phase; busy is high during the compare phase only.
// rst_n (asynchronous, active low) empties the table; slot contents are not cleared.
// Results are strobed by done for one cycle; the receiver cannot stall them.
`default_nettype none

module keyed_top_k_score_table
    import ktk_pkg::*;
#(
    parameter int NAME_BYTES = 8
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire item_t   item,
    output logic         done,
    output result_t      result
);

    localparam int KEY_W = NAME_BYTES * 8;

    // Sequencer phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CMP  = 2'd1;   // cells compare, flags registered
    localparam logic [1:0] PH_UPD  = 2'd2;   // cells load/shift, result registered

    logic [1:0]       phase_reg, phase_next;
    item_t            item_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ENTRIES-1:0] match_reg, gt_reg;
    result_t          result_reg, result_next;
    logic             done_reg;

    logic accept;

    // Cell row
    logic [KEY_W-1:0]      cell_key   [ENTRIES];
    logic [SCORE_BITS-1:0] cell_score [ENTRIES];
    cell_flags_t           cell_flags [ENTRIES];
    cell_ctl_t             cell_ctl   [ENTRIES];
    logic [ENTRIES-1:0]    cell_valid;

    logic [KEY_W-1:0]      probe_key;
    assign probe_key = item_reg.name_key[KEY_W-1:0];

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic [KEY_W-1:0]      left_key;
            logic [SCORE_BITS-1:0] left_score;
            if (g == 0)
            begin : g_head
                // head of the chain never shifts; feed it its own contents
                assign left_key   = cell_key[0];
                assign left_score = cell_score[0];
            end
            else
            begin : g_link
                assign left_key   = cell_key[g-1];
                assign left_score = cell_score[g-1];
            end

            assign cell_valid[g] = (CNT_W'(g) < count_reg);

            ktk_cell #(
                .KEY_W (KEY_W)
            ) u_cell (
                .clk         (clk),
                .probe_key   (probe_key),
                .probe_score (item_reg.new_score),
                .left_key    (left_key),
                .left_score  (left_score),
                .ctl         (cell_ctl[g]),
                .key         (cell_key[g]),
                .score       (cell_score[g]),
                .flags       (cell_flags[g])
            );
        end
    endgenerate

    // Handshake
    assign busy   = (phase_reg == PH_CMP);
    assign accept = start && !busy;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = PH_CMP;
        end
        else
        begin
            unique case (phase_reg)
                PH_CMP:  phase_next = PH_UPD;
                PH_UPD:  phase_next = PH_IDLE;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Update-phase decode. Scores are sorted descending, so the gt flags of the
    // valid cells form a suffix: the first set flag is where the item lands.
    logic             found;
    logic [IDX_W-1:0] found_pos;
    logic [CNT_W-1:0] lead;
    logic             full;
    logic             ignore_item;
    logic             drop_item;
    logic             place;
    logic [IDX_W-1:0] src_pos;    // slot the item leaves or the tail it enters at
    logic [IDX_W-1:0] dst_pos;    // slot the item ends in

    always_comb
    begin
        found     = |match_reg;
        found_pos = '0;
        lead      = count_reg;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                found_pos = IDX_W'(i);
            end
            if (gt_reg[i])
            begin
                lead = CNT_W'(i);
            end
        end

        full        = (count_reg == CNT_W'(ENTRIES));
        ignore_item = found && !gt_reg[found_pos];
        drop_item   = !found && full && !gt_reg[ENTRIES-1];
        place       = (phase_reg == PH_UPD) && (item_reg.opcode == OP_SUBMIT)
                      && !ignore_item && !drop_item;

        priority if (found)
        begin
            src_pos = found_pos;
        end
        else if (full)
        begin
            src_pos = IDX_W'(ENTRIES - 1);       // evict the tail
        end
        else
        begin
            src_pos = count_reg[IDX_W-1:0];
        end
        dst_pos = lead[IDX_W-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cell_ctl[i].load  = place && (IDX_W'(i) == dst_pos);
            cell_ctl[i].shift = place && (IDX_W'(i) > dst_pos) && (IDX_W'(i) <= src_pos);
        end
    end

    assign count_next = (place && !found && !full) ? count_reg + CNT_W'(1) : count_reg;

    // Result assembly
    logic read_hit;
    assign read_hit = ({1'b0, item_reg.read_index} < count_reg);

    always_comb
    begin
        result_next             = '0;
        result_next.entry_count = count_next;
        if (item_reg.opcode == OP_READ)
        begin
            if (read_hit)
            begin
                result_next.entry_valid = 1'b1;
                result_next.entry_key   = KEY_BITS'(cell_key[item_reg.read_index]);
                result_next.entry_score = cell_score[item_reg.read_index];
            end
        end
        else
        begin
            priority if (ignore_item)
            begin
                result_next.status = ST_IGNORED;
                result_next.rank   = CNT_W'(ENTRIES);
            end
            else if (drop_item)
            begin
                result_next.status = ST_DROPPED;
                result_next.rank   = CNT_W'(ENTRIES);
            end
            else
            begin
                result_next.status = found ? ST_IMPROVED : ST_ADDED;
                result_next.rank   = {1'b0, dst_pos};
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            done_reg  <= (phase_reg == PH_UPD);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (phase_reg == PH_CMP)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                match_reg[i] <= cell_flags[i].match && cell_valid[i];
                gt_reg[i]    <= cell_flags[i].gt && cell_valid[i];
            end
        end
        if (phase_reg == PH_UPD)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/ktk_cell.sv
// One table slot of the keyed top-k score table: holds a key and a score.
// Compares against the broadcast probe; loads the probe or shifts from its left neighbour.
// Depends on ktk_pkg.
`default_nettype none

module ktk_cell
    import ktk_pkg::*;
#(
    parameter int KEY_W = 64
)
(
    input  wire logic                  clk,
    input  wire logic [KEY_W-1:0]      probe_key,
    input  wire logic [SCORE_BITS-1:0] probe_score,
    input  wire logic [KEY_W-1:0]      left_key,
    input  wire logic [SCORE_BITS-1:0] left_score,
    input  wire cell_ctl_t             ctl,
    output logic [KEY_W-1:0]           key,
    output logic [SCORE_BITS-1:0]      score,
    output cell_flags_t                flags
);

    logic [KEY_W-1:0]      key_reg;
    logic [SCORE_BITS-1:0] score_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg   <= probe_key;
            score_reg <= probe_score;
        end
        else if (ctl.shift)
        begin
            key_reg   <= left_key;
            score_reg <= left_score;
        end
    end

    assign key         = key_reg;
    assign score       = score_reg;
    assign flags.match = (key_reg == probe_key);
    assign flags.gt    = (probe_score > score_reg);

endmodule

`default_nettype wire

FILE: rtl/ktk_checker.sv
// Port-level checks for the keyed top-k score table, bound to the top level.
// Depends on ktk_pkg and keyed_top_k_score_table.
`default_nettype none

module ktk_checker
    import ktk_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);

    // every accepted transaction is answered by a done strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing after accepted transaction");

    a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobes back to back");

    a_unplaced_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_IGNORED || result.status == ST_DROPPED))
        |-> (result.rank == CNT_W'(ENTRIES)))
        else $error("unplaced submit reports a table rank");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_count <= CNT_W'(ENTRIES)))
        else $error("entry count beyond table size");

endmodule

bind keyed_top_k_score_table ktk_checker u_ktk_checker (.*);

`default_nettype wire

FILE: tb/keyed_top_k_score_table_tb.sv
// Self-checking testbench for keyed_top_k_score_table: directed table, then random transactions.
// Every result is checked against a typed-in value or a behavioural copy of the ranked table kept here.
// Depends on ktk_pkg and the keyed_top_k_score_table RTL only.
`timescale 1ns / 100ps

module keyed_top_k_score_table_tb;
    import ktk_pkg::*;

    localparam int          NAME_BYTES = 8;
    localparam logic [63:0] KEY_MASK   = (NAME_BYTES >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);
    localparam int          RAND_ITEMS = 1300;
    localparam int          CYCLE_LIMIT = 100000;
    localparam int          REPORT_MAX = 10;

    // one row of the directed stimulus; want is only used when typed is set
    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    done;
    result_t result;

    // local copy of the ranked table, updated at each accepted transaction
    logic [63:0] rank_key[ENTRIES];
    logic [31:0] rank_score[ENTRIES];
    int          rank_count = 0;

    result_t     expected_outcomes[$];
    dir_row_t    dir_rows[$];
    int          fail_cnt = 0;
    int          result_cnt = 0;
    int          cycle_cnt = 0;
    logic [63:0] key_pool[24];

    keyed_top_k_score_table #(
        .NAME_BYTES (NAME_BYTES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one transaction to the local table and return the result it should give.
    // Ties keep arrival order: a new or raised entry only passes strictly lower scores.
    function automatic result_t rank_table_apply(item_t it);
        result_t     r;
        logic [63:0] k;
        logic [31:0] s;
        int          pos;
        int          i;
        bit          found;
        r     = '0;
        k     = it.name_key & KEY_MASK;
        s     = it.new_score;
        found = 1'b0;
        pos   = rank_count;
        if (it.opcode == OP_READ)
        begin
            if (int'(it.read_index) < rank_count)
            begin
                r.entry_valid = 1'b1;
                r.entry_key   = rank_key[it.read_index];
                r.entry_score = rank_score[it.read_index];
            end
        end
        else
        begin
            for (i = 0; i < rank_count; i++)
            begin
                if (!found && rank_key[i] == k)
                begin
                    found = 1'b1;
                    pos   = i;
                end
            end
            if (found && s <= rank_score[pos])
            begin
                // known key, no improvement
                r.status = ST_IGNORED;
                r.rank   = CNT_W'(ENTRIES);
            end
            else if (!found && rank_count >= ENTRIES && s <= rank_score[ENTRIES-1])
            begin
                // full and not good enough to evict the tail
                r.status = ST_DROPPED;
                r.rank   = CNT_W'(ENTRIES);
            end
            else
            begin
                if (!found)
                begin
                    if (rank_count < ENTRIES)
                        rank_count++;
                    else
                        pos = ENTRIES - 1;     // tail is evicted
                    r.status = ST_ADDED;
                end
                else
                begin
                    r.status = ST_IMPROVED;
                end
                while (pos > 0 && s > rank_score[pos-1])
                begin
                    rank_key[pos]   = rank_key[pos-1];
                    rank_score[pos] = rank_score[pos-1];
                    pos--;
                end
                rank_key[pos]   = k;
                rank_score[pos] = s;
                r.rank          = CNT_W'(pos);
            end
        end
        r.entry_count = CNT_W'(rank_count);
        return r;
    endfunction

    function automatic item_t submit_item(logic [63:0] k, logic [31:0] s);
        item_t it;
        it            = '0;
        it.opcode     = OP_SUBMIT;
        it.name_key   = k;
        it.new_score  = s;
        it.read_index = IDX_W'($urandom);
        return it;
    endfunction

    function automatic item_t read_item(int idx);
        item_t it;
        it            = '0;
        it.opcode     = OP_READ;
        it.name_key   = {$urandom, $urandom};
        it.new_score  = $urandom;
        it.read_index = IDX_W'(idx);
        return it;
    endfunction

    function automatic result_t submit_outcome(logic [1:0] st, int rk, int cnt);
        result_t r;
        r             = '0;
        r.status      = st;
        r.rank        = CNT_W'(rk);
        r.entry_count = CNT_W'(cnt);
        return r;
    endfunction

    function automatic result_t read_outcome(int cnt, logic [63:0] k, logic [31:0] s);
        result_t r;
        r             = '0;
        r.entry_count = CNT_W'(cnt);
        r.entry_valid = 1'b1;
        r.entry_key   = k;
        r.entry_score = s;
        return r;
    endfunction

    // Random transaction shaped to keep the table busy near its edges:
    // reads of valid ranks, resubmits of held keys around their score, keys
    // from a fixed pool, and any key scored around the tail once the table is full.
    function automatic item_t random_item();
        logic [63:0] k;
        logic [31:0] s;
        int          sel;
        int          idx;
        sel = $urandom_range(99);
        if (rank_count > 0 && sel < 30)
            return read_item($urandom_range(rank_count - 1));
        sel = $urandom_range(99);
        idx = -1;
        if (sel < 50)
            k = key_pool[$urandom_range(23)];
        else if (sel < 70 || rank_count == 0)
            k = {$urandom, $urandom};
        else
        begin
            idx = $urandom_range(rank_count - 1);
            k   = rank_key[idx];
        end
        sel = $urandom_range(99);
        if (sel < 35)
            s = $urandom;
        else if (sel < 65 && rank_count == ENTRIES)
            s = rank_score[ENTRIES-1] + 32'($urandom_range(3)) - 32'd1;
        else if (sel < 90 && idx >= 0)
            s = rank_score[idx] + 32'($urandom_range(3)) - 32'd1;
        else if (sel < 95)
            s = 32'hFFFF_FFFF;
        else
            s = $urandom_range(2);
        return submit_item(k, s);
    endfunction

    // Present one transaction and hold it until the block takes it. Called just
    // after a rising edge; start is left high so the next call can follow at once.
    task automatic issue(item_t it, bit typed, result_t want);
        result_t predicted;
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = rank_table_apply(it);
        expected_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic pause_random();
        if ($urandom_range(99) < 13)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_outstanding();
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Result checker: done is a one-cycle strobe that cannot be held off,
    // so every strobe is taken at the edge that ends it.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            result_cnt++;
            if (expected_outcomes.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display("result %0d: no transaction outstanding, got st=%0d rk=%0d cnt=%0d",
                             result_cnt, result.status, result.rank, result.entry_count);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (result.status !== want.status || result.rank !== want.rank ||
                    result.entry_count !== want.entry_count ||
                    result.entry_valid !== want.entry_valid ||
                    result.entry_key !== want.entry_key ||
                    result.entry_score !== want.entry_score)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                    begin
                        $display("result %0d: want st=%0d rk=%0d cnt=%0d v=%0b key=%h sc=%h",
                                 result_cnt, want.status, want.rank, want.entry_count,
                                 want.entry_valid, want.entry_key, want.entry_score);
                        $display("result %0d: got  st=%0d rk=%0d cnt=%0d v=%0b key=%h sc=%h",
                                 result_cnt, result.status, result.rank, result.entry_count,
                                 result.entry_valid, result.entry_key, result.entry_score);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("keyed_top_k_score_table: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_c;
        logic [63:0] filler;
        int          i;
        int          n;

        key_a  = 64'hFFFF_FFFF_FFFF_FFFF;
        key_b  = 64'h0000_0000_0000_0001;
        key_c  = 64'h8000_0000_0000_0000;
        filler = 64'h00C0_FFEE_0000_0000;
        for (i = 0; i < 24; i++)
            key_pool[i] = {$urandom, $urandom};

        // Directed table. Expected values typed in where they are plain;
        // the rest go through the local table.
        // read of an empty table straight after reset
        dir_rows.push_back('{read_item(0), 1'b1, '0});
        dir_rows.push_back('{submit_item(key_a, 32'hFFFF_FFFF), 1'b1,
                             submit_outcome(ST_ADDED, 0, 1)});
        dir_rows.push_back('{read_item(0), 1'b1, read_outcome(1, key_a, 32'hFFFF_FFFF)});
        // known key, lower then equal score: ignored
        dir_rows.push_back('{submit_item(key_a, 32'd5), 1'b1,
                             submit_outcome(ST_IGNORED, ENTRIES, 1)});
        dir_rows.push_back('{submit_item(key_a, 32'hFFFF_FFFF), 1'b1,
                             submit_outcome(ST_IGNORED, ENTRIES, 1)});
        dir_rows.push_back('{submit_item(64'd0, 32'd0), 1'b1,
                             submit_outcome(ST_ADDED, 1, 2)});
        dir_rows.push_back('{submit_item(64'd0, 32'd0), 1'b1,
                             submit_outcome(ST_IGNORED, ENTRIES, 2)});
        dir_rows.push_back('{submit_item(64'd0, 32'd100), 1'b1,
                             submit_outcome(ST_IMPROVED, 1, 2)});
        // new key on an equal score lands behind it
        dir_rows.push_back('{submit_item(key_b, 32'd100), 1'b1,
                             submit_outcome(ST_ADDED, 2, 3)});
        dir_rows.push_back('{submit_item(key_c, 32'd50), 1'b0, '0});
        // raise past two equal entries
        dir_rows.push_back('{submit_item(key_c, 32'd101), 1'b0, '0});
        // read past the valid entries
        dir_rows.push_back('{read_item(9), 1'b0, '0});
        // fill to capacity, descending 31..20
        for (i = 11; i >= 0; i--)
            dir_rows.push_back('{submit_item(filler | 64'(i), 32'(20 + i)), 1'b0, '0});
        // full, new key equal to the tail: dropped
        dir_rows.push_back('{submit_item(64'h1234_5678_9ABC_DEF0, 32'd20), 1'b1,
                             submit_outcome(ST_DROPPED, ENTRIES, ENTRIES)});
        // full, new key just above the tail: tail evicted
        dir_rows.push_back('{submit_item(64'h1234_5678_9ABC_DEF0, 32'd21), 1'b0, '0});
        // evicted key comes back too low: dropped
        dir_rows.push_back('{submit_item(filler, 32'd0), 1'b1,
                             submit_outcome(ST_DROPPED, ENTRIES, ENTRIES)});
        // raise to the top score, stays behind the equal leader
        dir_rows.push_back('{submit_item(filler | 64'd11, 32'hFFFF_FFFF), 1'b0, '0});
        dir_rows.push_back('{read_item(15), 1'b0, '0});
        dir_rows.push_back('{read_item(0), 1'b1,
                             read_outcome(ENTRIES, key_a, 32'hFFFF_FFFF)});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < dir_rows.size(); n++)
        begin
            pause_random();
            issue(dir_rows[n].it, dir_rows[n].typed, dir_rows[n].want);
        end

        // hold off until the directed part has fully come back
        drain_outstanding();
        @(posedge clk);

        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 400 == 399)
                drain_outstanding();
            else if (n < 500 || n >= 800)     // 500..798 run back to back
                pause_random();
            issue(random_item(), 1'b0, '0);
        end

        drain_outstanding();
        repeat (6) @(posedge clk);

        if (fail_cnt == 0)
            $display("keyed_top_k_score_table: match");
        else
            $display("keyed_top_k_score_table: mismatch");
        $finish;
    end

endmodule

FILE: keyed_top_k_score_table.f
rtl/ktk_pkg.sv
rtl/ktk_cell.sv
rtl/keyed_top_k_score_table.sv
rtl/ktk_checker.sv
tb/keyed_top_k_score_table_tb.sv
